// File: hw/rtl/stkf_pkg.sv
// ----------------------------------------------------------------------------
// stkf_pkg: shared types and constants for the seed-to-key Feistel block
// Round word table, half-word type and the round count default.
// ----------------------------------------------------------------------------
package stkf_pkg;

  localparam int NUM_ROUNDS_DEF = 19;
  localparam int TABLE_WORDS    = 19;
  localparam int TBL_IDX_W      = 5;
  localparam int HALF_W         = 16;
  localparam int SEED_W         = 32;

  typedef logic [HALF_W-1:0] half_t;

  typedef struct packed {
    half_t hi;
    half_t lo;
  } halves_t;

  localparam half_t ROUND_WORDS [TABLE_WORDS] = '{
    16'h107C, 16'h9237, 16'hDC9D, 16'h6422, 16'h7C21, 16'h2033, 16'h5572,
    16'h85BE, 16'hC5AF, 16'h3F16, 16'hA257, 16'h7BCA, 16'h34F9, 16'h7334,
    16'h143F, 16'h51DE, 16'hFD3E, 16'h2EE6, 16'h3EF8
  };

endpackage

// File: hw/rtl/stkf_round.sv
// ----------------------------------------------------------------------------
// stkf_round: one Feistel round
// Computes the round function on the low half and forms the next halves.
// ----------------------------------------------------------------------------
module stkf_round (
  input  stkf_pkg::halves_t cur,
  input  stkf_pkg::half_t   word,
  output stkf_pkg::halves_t nxt
);
  import stkf_pkg::*;

  half_t t;
  half_t t_shl;
  half_t f;
  logic  par;

  always_comb begin
    t     = cur.lo ^ word;
    par   = t[15] ^ t[4] ^ t[2] ^ t[1];
    t_shl = {t[14:0], par};
    // swap bytes, then mix the word back in
    f     = {t_shl[7:0], t_shl[15:8]} ^ word;
    nxt.hi = cur.hi ^ f;
    nxt.lo = cur.hi;
  end

endmodule

// File: hw/rtl/seed_to_key_feistel.sv
// ----------------------------------------------------------------------------
// seed_to_key_feistel: security seed-to-key transform
// Runs a 32-bit seed through NUM_ROUNDS Feistel rounds, one round per cycle.
// ----------------------------------------------------------------------------
// The final round is held while a stalled result still occupies the output
// register. A single round unit is reused for every round, so a new seed is
// taken only after the current key has been written to the output register.
// in_stall is high while a seed is being worked on.
// Reset (rst_n low, synchronous) returns to idle and drops any pending result.
module seed_to_key_feistel #(
  parameter int NUM_ROUNDS = stkf_pkg::NUM_ROUNDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [stkf_pkg::SEED_W-1:0] in_seed,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [stkf_pkg::SEED_W-1:0] out_key
);
  import stkf_pkg::*;

  localparam int RND_W = (NUM_ROUNDS > 1) ? $clog2(NUM_ROUNDS) : 1;
  localparam logic [RND_W-1:0] LAST_RND = RND_W'(NUM_ROUNDS - 1);

  // sequencer states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic             state_r,     state_nxt;
  logic [RND_W-1:0] rnd_r,       rnd_nxt;
  halves_t          data_r,      data_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [SEED_W-1:0] out_key_r,  out_key_nxt;

  half_t   word;
  halves_t rnd_out;
  logic    in_acc;
  logic    out_free;
  logic    last_rnd;

  // shared round unit, fed from the working halves every cycle
  assign word = ROUND_WORDS[TBL_IDX_W'(rnd_r)];

  stkf_round u_round (
    .cur  (data_r),
    .word (word),
    .nxt  (rnd_out)
  );

  assign in_stall = (state_r == ST_RUN);
  assign in_acc   = in_valid && !in_stall;
  // output register can take a new key if empty or being drained now
  assign out_free = !out_valid_r || !out_stall;
  assign last_rnd = (rnd_r == LAST_RND);

  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    data_nxt      = data_r;
    out_valid_nxt = out_valid_r;
    out_key_nxt   = out_key_r;

    // drop the result once the receiver takes it
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          data_nxt  = in_seed;
          rnd_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!last_rnd) begin
          // advance one round
          data_nxt = rnd_out;
          rnd_nxt  = rnd_r + RND_W'(1);
        end else if (out_free) begin
          // finish: final round goes straight into the output register
          out_key_nxt   = rnd_out;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
        // else hold the last round until the output register frees up
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r    <= data_nxt;
    out_key_r <= out_key_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_key   = out_key_r;

  // accepted seed starts at round zero
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_RUN) && (rnd_r == '0))
    else $error("round sequence did not start at round zero");

  // round counter never passes the last round while running
  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (rnd_r <= LAST_RND))
    else $error("round counter out of range");

  // a new result only appears at the end of a run
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RUN) && $past(last_rnd))
    else $error("result produced outside the final round");

  // intermediate rounds never stall
  a_no_early_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) && !last_rnd |=> (state_r == ST_RUN))
    else $error("run ended before the last round");

  // no result is overwritten while the receiver stalls
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_key_r))
    else $error("result overwritten under stall");

endmodule

// File: sim/seed_key_checker.sv
// ----------------------------------------------------------------------------
// seed_key_checker: key predictor and result scoreboard
// Watches both channels of the seed-to-key block, predicts each key from the
// accepted seed and compares it with the next key the block hands out.
// ----------------------------------------------------------------------------
module seed_key_checker #(
  parameter int NUM_ROUNDS = stkf_pkg::NUM_ROUNDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [stkf_pkg::SEED_W-1:0] in_seed,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [stkf_pkg::SEED_W-1:0] out_key,
  output int unsigned                 fail_count,
  output int unsigned                 outstanding
);

  import stkf_pkg::*;

  logic [SEED_W-1:0] expected_keys [$];
  logic [SEED_W-1:0] want_key;
  int unsigned       error_total = 0;

  // Feistel network over the two halves, one table word per round.
  function automatic logic [SEED_W-1:0] derive_key(input logic [SEED_W-1:0] seed);
    half_t hi;
    half_t lo;
    half_t word;
    half_t mix;
    half_t rotated;
    logic  par;
    int    r;
    hi = seed[31:16];
    lo = seed[15:0];
    for (r = 0; r < NUM_ROUNDS; r++) begin
      word    = ROUND_WORDS[r % TABLE_WORDS];
      mix     = lo ^ word;
      par     = mix[15] ^ mix[4] ^ mix[2] ^ mix[1];
      rotated = {mix[14:0], par};
      mix     = {rotated[7:0], rotated[15:8]} ^ word;
      lo      = hi;
      hi      = hi ^ mix;
    end
    return {hi, lo};
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_keys.delete();
      outstanding <= 0;
      fail_count  <= error_total;
    end else begin
      if (in_valid && !in_stall) begin
        expected_keys.push_back(derive_key(in_seed));
      end
      if (out_valid && !out_stall) begin
        if (expected_keys.size() == 0) begin
          $error("key: unexpected result, expected none, actual 0x%08h", out_key);
          error_total++;
        end else begin
          want_key = expected_keys.pop_front();
          if (out_key !== want_key) begin
            $error("key: mismatch, expected 0x%08h, actual 0x%08h", want_key, out_key);
            error_total++;
          end
        end
      end
      fail_count  <= error_total;
      outstanding <= expected_keys.size();
    end
  end

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: regression bench for the seed-to-key Feistel block
// Drives directed and random seeds with random gaps and receiver stalls,
// including a long receiver hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;

  import stkf_pkg::*;

  localparam int ROUNDS      = NUM_ROUNDS_DEF;
  localparam int RANDOM_SEEDS = 1600;
  localparam int PAUSE_AT    = 800;    // sender drains the block here
  localparam int HOLD_AT     = 300;    // receiver starts its long hold-off here
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int N_DIRECTED  = 22;

  // Low half patterns aimed at the first round word: mix of zero, then the
  // parity taps (bits 15, 4, 2, 1) lit one at a time and in combination.
  localparam logic [SEED_W-1:0] DIRECTED_SEEDS [N_DIRECTED] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_0000,
    32'h0000_0001, 32'h8000_0000, 32'h0000_8000, 32'h0001_0000,
    32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_107C, 32'h0000_907C,
    32'h0000_106C, 32'h0000_1078, 32'h0000_107E, 32'h0000_906A,
    32'hFFFF_107C, 32'h1234_5678, 32'hDEAD_BEEF, 32'h7FFF_FFFF,
    32'hFFFF_FFFE, 32'h00FF_FF00
  };

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [SEED_W-1:0] in_seed;
  logic              out_valid;
  logic              out_stall;
  logic [SEED_W-1:0] out_key;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned seeds_sent;
  int unsigned cycle_count = 0;
  bit          hold_done = 1'b0;

  // 4-unit clock period.
  always #2 clk = ~clk;

  seed_to_key_feistel #(
    .NUM_ROUNDS (ROUNDS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_seed   (in_seed),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_key   (out_key)
  );

  seed_key_checker #(
    .NUM_ROUNDS (ROUNDS)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_seed     (in_seed),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_key     (out_key),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Mostly short gaps, roughly one in ten long; burst stretches get none.
  function automatic int unsigned pick_gap(input bit burst);
    if (burst) begin
      return 0;
    end
    if ($urandom_range(9) == 0) begin
      return $urandom_range(80, 20);
    end
    return $urandom_range(3);
  endfunction

  // Offer one seed and hold it until the block takes the transaction.
  task automatic send_seed(input logic [SEED_W-1:0] seed);
    in_valid <= 1'b1;
    in_seed  <= seed;
    do @(posedge clk); while (in_stall);
    seeds_sent++;
  endtask

  // Drop valid for a number of cycles; zero keeps the stream back to back.
  task automatic sender_gap(input int unsigned cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Hold the sender until every predicted key has come back.
  task automatic drain_block();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Watchdog: end the run if it never converges.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: random stall stretches, plus one long hold-off once the
  // stream is well under way so the block fills and stalls its input.
  initial begin
    bit          burst;
    int unsigned stall_len;
    int unsigned run_len;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!hold_done && seeds_sent >= HOLD_AT) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      burst     = ($urandom_range(4) == 0);
      stall_len = pick_gap(burst);
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      run_len = burst ? $urandom_range(120, 40) : $urandom_range(30, 1);
      repeat (run_len) @(posedge clk);
    end
  end

  // Stimulus and verdict.
  initial begin
    bit burst;
    int i;
    seeds_sent  = 0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_seed  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed seeds: field extremes and parity-tap patterns.
    for (i = 0; i < N_DIRECTED; i++) begin
      send_seed(DIRECTED_SEEDS[i]);
      sender_gap(pick_gap(1'b0));
    end
    drain_block();

    // Random seeds; every third stretch of 128 runs back to back.
    for (i = 0; i < RANDOM_SEEDS; i++) begin
      if (i == PAUSE_AT) begin
        drain_block();
      end
      burst = ((i / 128) % 3 == 2);
      send_seed($urandom());
      sender_gap(pick_gap(burst));
    end
    in_valid <= 1'b0;

    // Wait out the last keys, then a margin for anything stray.
    do @(posedge clk); while (outstanding != 0);
    repeat (ROUNDS * 4) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
